// File: src/rfe_pkg.sv
// Shared types and constants for the reduced fraction enumerator.
// No dependencies; rfe_gcd, the top level and the checker take their names from here by scope.
package rfe_pkg;

  // Denominator limits: the configured limit is clamped to the smaller of these.
  localparam int unsigned MaxDenom = 128;
  localparam int unsigned DenomCap = 128;
  localparam int unsigned LimCap   = (MaxDenom < DenomCap) ? MaxDenom : DenomCap;

  localparam logic [7:0] LimCapW  = 8'(LimCap);
  localparam logic [7:0] CfgReset = 8'd2;
  localparam logic [6:0] FirstNum = 7'd1;
  localparam logic [7:0] FirstDen = 8'd2;

  typedef struct packed {
    logic restart;
  } req_t;

  typedef struct packed {
    logic [6:0] numerator;
    logic [7:0] denominator;
    logic       valid_res;
    logic       last;
  } res_t;

  typedef struct packed {
    logic done;
    logic coprime;
  } gcd_status_t;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StCheck = 4'b0010,
    StGcd   = 4'b0100,
    StOut   = 4'b1000
  } state_e;

endpackage

// File: src/rfe_stream_if.sv
// Valid/ready channel carrying one payload item per transfer.
// Payload type is given at instantiation (rfe_pkg::req_t or rfe_pkg::res_t).
interface rfe_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: src/rfe_gcd.sv
// Iterative binary gcd unit: one shift or subtract per cycle.
// Reports whether the two operands are coprime. Uses rfe_pkg.
module rfe_gcd (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [7:0]                a_i,
  input  logic [7:0]                b_i,
  output rfe_pkg::gcd_status_t      status_o
);

  logic [7:0] a_q, a_d, b_q, b_d;
  logic       run_q, run_d;
  logic       equal, both_even, finish;

  assign equal     = (a_q == b_q);
  assign both_even = !a_q[0] && !b_q[0];
  assign finish    = equal || both_even;

  always_comb begin
    a_d   = a_q;
    b_d   = b_q;
    run_d = run_q;
    if (start_i) begin
      a_d   = a_i;
      b_d   = b_i;
      run_d = 1'b1;
    end else if (run_q) begin
      priority if (finish) begin
        run_d = 1'b0;
      end else if (!a_q[0]) begin
        a_d = a_q >> 1;
      end else if (!b_q[0]) begin
        b_d = b_q >> 1;
      end else if (a_q > b_q) begin
        a_d = a_q - b_q;
      end else begin
        b_d = b_q - a_q;
      end
    end
  end

  // Operands are nonzero and never equal when subtracted, so they stay nonzero.
  assign status_o.done    = run_q && finish;
  assign status_o.coprime = equal && (a_q == 8'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else begin
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
  end

endmodule

// File: src/reduced_fraction_enumerator_top.sv
// Reduced fraction enumerator: one request in, one fraction (or end mark) out.
// Each request is taken in idle; candidate pairs are then checked and run through
// the gcd unit (8-bit operands), a lookahead search follows for the last flag, and
// the result is handed back; one item at a time.
// Throughput is set by the shared gcd unit walking candidate pairs.
// Reset (async, active low): position 1/2, not exhausted, limit 2, idle.
module reduced_fraction_enumerator_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  rfe_stream_if.sink         req_i,
  rfe_stream_if.source       res_o
);

  rfe_pkg::state_e      state_q, state_d;
  logic [7:0]           cfg_q, cfg_d;
  logic [6:0]           nn_q, nn_d;
  logic [7:0]           nd_q, nd_d;
  logic                 exh_q, exh_d;
  logic                 look_q, look_d;
  logic [6:0]           cn_q, cn_d;
  logic [7:0]           cd_q, cd_d;
  rfe_pkg::res_t        res_q, res_d;

  logic [7:0]           lim;
  logic [6:0]           adv_n;
  logic [7:0]           adv_d;
  logic                 gcd_start;
  rfe_pkg::gcd_status_t gcd_st;
  logic [6:0]           s_n;
  logic [7:0]           s_d;
  logic                 s_x;

  rfe_gcd u_gcd (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (gcd_start),
    .a_i      (cd_q),
    .b_i      ({1'b0, cn_q}),
    .status_o (gcd_st)
  );

  // Clamp the limit into 1..LimCap.
  always_comb begin
    lim = (cfg_q > rfe_pkg::LimCapW) ? rfe_pkg::LimCapW : cfg_q;
    if (lim == 8'd0) lim = 8'd1;
  end

  // Next candidate in enumeration order.
  always_comb begin
    if (({1'b0, cn_q} + 8'd1) < cd_q) begin
      adv_n = cn_q + 7'd1;
      adv_d = cd_q;
    end else begin
      adv_n = rfe_pkg::FirstNum;
      adv_d = cd_q + 8'd1;
    end
  end

  assign cfg_d = cfg_we_i ? cfg_wdata_i : cfg_q;

  assign s_n = req_i.payload.restart ? rfe_pkg::FirstNum : nn_q;
  assign s_d = req_i.payload.restart ? rfe_pkg::FirstDen : nd_q;
  assign s_x = req_i.payload.restart ? 1'b0 : exh_q;

  always_comb begin
    state_d   = state_q;
    nn_d      = nn_q;
    nd_d      = nd_q;
    exh_d     = exh_q;
    look_d    = look_q;
    cn_d      = cn_q;
    cd_d      = cd_q;
    res_d     = res_q;
    gcd_start = 1'b0;
    unique case (state_q)
      rfe_pkg::StIdle: begin
        if (req_i.valid) begin
          nn_d   = s_n;
          nd_d   = s_d;
          exh_d  = s_x;
          cn_d   = s_n;
          cd_d   = s_d;
          look_d = 1'b0;
          res_d  = '0;
          state_d = s_x ? rfe_pkg::StOut : rfe_pkg::StCheck;
        end
      end
      rfe_pkg::StCheck: begin
        priority if (cd_q > lim) begin
          // Search ran past the limit.
          exh_d = 1'b1;
          if (!look_q) begin
            nn_d  = cn_q;
            nd_d  = cd_q;
            res_d = '0;
          end else begin
            res_d.last = 1'b1;
          end
          state_d = rfe_pkg::StOut;
        end else if (cn_q == 7'd0 || {1'b0, cn_q} >= cd_q) begin
          cn_d = rfe_pkg::FirstNum;
          cd_d = cd_q + 8'd1;
        end else begin
          gcd_start = 1'b1;
          state_d   = rfe_pkg::StGcd;
        end
      end
      rfe_pkg::StGcd: begin
        if (gcd_st.done) begin
          if (gcd_st.coprime && look_q) begin
            state_d = rfe_pkg::StOut;
          end else begin
            if (gcd_st.coprime) begin
              // Emit this pair, save the position, then look ahead for the last flag.
              res_d.numerator   = cn_q;
              res_d.denominator = cd_q;
              res_d.valid_res   = 1'b1;
              res_d.last        = 1'b0;
              nn_d   = adv_n;
              nd_d   = adv_d;
              look_d = 1'b1;
            end
            cn_d    = adv_n;
            cd_d    = adv_d;
            state_d = rfe_pkg::StCheck;
          end
        end
      end
      rfe_pkg::StOut: begin
        if (res_o.ready) state_d = rfe_pkg::StIdle;
      end
      default: state_d = rfe_pkg::StIdle;
    endcase
  end

  assign req_i.ready   = (state_q == rfe_pkg::StIdle);
  assign res_o.valid   = (state_q == rfe_pkg::StOut);
  assign res_o.payload = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rfe_pkg::StIdle;
      cfg_q   <= rfe_pkg::CfgReset;
      nn_q    <= rfe_pkg::FirstNum;
      nd_q    <= rfe_pkg::FirstDen;
      exh_q   <= 1'b0;
      look_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cfg_q   <= cfg_d;
      nn_q    <= nn_d;
      nd_q    <= nd_d;
      exh_q   <= exh_d;
      look_q  <= look_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cn_q  <= cn_d;
    cd_q  <= cd_d;
    res_q <= res_d;
  end

endmodule

// File: src/rfe_checker.sv
// Port-level checks for the reduced fraction enumerator, bound to the top level.
// Depends on rfe_pkg and reduced_fraction_enumerator_top.
module rfe_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          req_valid_i,
  input logic          req_ready_i,
  input logic          res_valid_i,
  input logic          res_ready_i,
  input rfe_pkg::res_t res_payload_i
);

  // Hold a stalled result.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_payload_i))
    else $error("result changed while stalled");

  // End-of-list answers carry no fraction and no last flag.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_payload_i.valid_res |->
      res_payload_i.numerator == 7'd0 && res_payload_i.denominator == 8'd0 &&
      !res_payload_i.last)
    else $error("invalid result with nonzero fields");

  // Emitted fractions lie strictly between 0 and 1 within the cap.
  a_proper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_payload_i.valid_res |->
      res_payload_i.numerator != 7'd0 &&
      {1'b0, res_payload_i.numerator} < res_payload_i.denominator &&
      res_payload_i.denominator <= rfe_pkg::LimCapW)
    else $error("fraction out of range");

  // One item at a time: taking a request drops ready.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while busy");

endmodule

bind reduced_fraction_enumerator_top rfe_checker u_rfe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .res_payload_i (res_o.payload)
);
